FILE: design/sef_pkg.sv
package sef_pkg;

   // operation codes carried in req_tuser
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   // field widths
   localparam int COORD_W = 9;
   localparam int EXT_W   = 10;
   localparam int FRAC_W  = 16;

   // q10.16 position and slope, signed
   localparam int XW = 27;

   // slope division: |dx| << 16 divided by dy, one quotient bit a step
   localparam int DIVIDEND_W = COORD_W + FRAC_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   // stream packing
   localparam int REQ_FIELDS_W = 4 * COORD_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = COORD_W + 2 * EXT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [XW-1:0]      fixed_type;

endpackage

FILE: design/sef_ram.sv
module sef_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 512
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scanline_span_extent_fill_top.sv
// a clear writes every row of the extent ram in S_CLEAR; a read issues in S_RD_ISS and
//   registers its response in S_RD_DATA, which waits while the last response is stalled
// add edge: S_DIV (slope division, one quotient bit a step, skipped for a horizontal edge),
//   then S_WALK (one row per cycle, each row read and then written back), then S_DRAIN
// one request at a time: req_tready is low until the current request is finished
// reset (synchronous, active high) clears the extent ram one row a cycle, req_tready held low
module scanline_span_extent_fill_top #(
   parameter int SCREEN_SIZE = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sef_pkg::REQ_DATA_W-1:0]    req_tdata,  // start_x, start_y, end_x, end_y
   input  logic [sef_pkg::OP_W-1:0]          req_tuser,  // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sef_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // span_row, span_left, span_right
   output logic [0:0]                        rsp_tuser   // span_empty
);

   import sef_pkg::*;

   // ram geometry: one word per row holds {left, right}
   localparam int AW       = (SCREEN_SIZE > 1) ? $clog2(SCREEN_SIZE) : 1;
   localparam int EXT_BITS = $clog2(SCREEN_SIZE + 1);
   localparam int SW       = (EXT_BITS > COORD_W) ? EXT_BITS : COORD_W;
   localparam int WORD_W   = 2 * SW;

   // sequencer states
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DIV     = 3'd2;
   localparam logic [2:0] S_WALK    = 3'd3;
   localparam logic [2:0] S_DRAIN   = 3'd4;
   localparam logic [2:0] S_RD_ISS  = 3'd5;
   localparam logic [2:0] S_RD_DATA = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [COORD_W-1:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [COORD_W-1:0]    dy_ff, dy_in;
   logic                  neg_ff, neg_in;
   fixed_type             slope_ff, slope_in;
   fixed_type             x_ff, x_in;
   coord_type             row_ff, row_in;
   coord_type             y_hi_ff, y_hi_in;

   // write-back stage of the row read-modify-write
   logic                  wr_pend_ff, wr_pend_in;
   coord_type             wr_row_ff, wr_row_in;
   coord_type             wr_px_ff, wr_px_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   coord_type             rsp_row_ff, rsp_row_in;
   logic [EXT_W-1:0]      rsp_left_ff, rsp_left_in;
   logic [EXT_W-1:0]      rsp_right_ff, rsp_right_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   // request fields
   coord_type             start_x, start_y, end_x, end_y;
   coord_type             x_lo, y_lo, x_hi, y_hi;
   logic                  accept;

   // shared adder: divider trial subtract and x stepping
   fixed_type             alu_a, alu_b, alu_sum;
   logic                  alu_sub;

   // divider step
   logic [COORD_W:0]      trial;
   logic                  q_bit;
   logic [DIVIDEND_W-1:0] quo_next;

   // ram ports
   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0]     ram_wr_data, ram_rd_data;
   logic [SW-1:0]         cur_left, cur_right, px_ext, new_left, new_right;
   logic                  wr_row_ok, rd_row_ok;
   logic [SW-1:0]         rd_left, rd_right;
   logic                  out_free;

   assign start_x = req_tdata[COORD_W-1:0];
   assign start_y = req_tdata[2*COORD_W-1:COORD_W];
   assign end_x   = req_tdata[3*COORD_W-1:2*COORD_W];
   assign end_y   = req_tdata[4*COORD_W-1:3*COORD_W];

   // order the endpoints by y; equal rows keep the first endpoint low
   assign x_lo = (start_y > end_y) ? end_x : start_x;
   assign y_lo = (start_y > end_y) ? end_y : start_y;
   assign x_hi = (start_y > end_y) ? start_x : end_x;
   assign y_hi = (start_y > end_y) ? start_y : end_y;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // shared adder
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   always_comb begin
      alu_a   = x_ff;
      alu_b   = slope_ff;
      alu_sub = 1'b0;
      if (state_ff == S_DIV) begin
         alu_a   = XW'(trial);
         alu_b   = XW'(dy_ff);
         alu_sub = 1'b1;
      end
   end
   assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   // restoring division: keep the difference when it did not go negative
   assign q_bit    = ~alu_sum[XW-1];
   assign quo_next = {quo_ff[DIVIDEND_W-2:0], q_bit};

   // row bounds
   assign wr_row_ok = ({23'd0, wr_row_ff} < 32'(SCREEN_SIZE));
   assign rd_row_ok = ({23'd0, row_ff} < 32'(SCREEN_SIZE));

   // widen the extents of the row whose word has just come back
   assign cur_left  = ram_rd_data[WORD_W-1:SW];
   assign cur_right = ram_rd_data[SW-1:0];
   assign px_ext    = SW'(wr_px_ff);
   assign new_left  = (px_ext < cur_left) ? px_ext : cur_left;
   assign new_right = (px_ext > cur_right) ? px_ext : cur_right;

   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = {SW'(SCREEN_SIZE), SW'(0)};
      end else begin
         ram_wr_en   = wr_pend_ff && wr_row_ok;
         ram_wr_addr = AW'(wr_row_ff);
         ram_wr_data = {new_left, new_right};
      end
   end

   assign ram_rd_en   = (state_ff == S_WALK) || (state_ff == S_RD_ISS);
   assign ram_rd_addr = AW'(row_ff);

   sef_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SCREEN_SIZE)
   ) u_ext_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // rows outside the store read as an empty span
   assign rd_left  = rd_row_ok ? cur_left : SW'(SCREEN_SIZE);
   assign rd_right = rd_row_ok ? cur_right : SW'(0);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      div_cnt_in = div_cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dy_in      = dy_ff;
      neg_in     = neg_ff;
      slope_in   = slope_ff;
      x_in       = x_ff;
      row_in     = row_ff;
      y_hi_in    = y_hi_ff;
      wr_pend_in = 1'b0;
      wr_row_in  = wr_row_ff;
      wr_px_in   = wr_px_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_empty_in = rsp_empty_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(SCREEN_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_CLEAR: begin
                     clr_cnt_in = AW'(0);
                     state_in   = S_CLEAR;
                  end
                  OP_ADD: begin
                     neg_in     = (x_hi < x_lo);
                     quo_in     = {((x_hi < x_lo) ? (x_lo - x_hi) : (x_hi - x_lo)),
                                   FRAC_W'(0)};
                     rem_in     = '0;
                     dy_in      = y_hi - y_lo;
                     div_cnt_in = '0;
                     x_in       = XW'({x_lo, FRAC_W'(0)});
                     row_in     = y_lo;
                     y_hi_in    = y_hi;
                     // horizontal edge: a single row at start_x, no slope
                     if (y_hi == y_lo) begin
                        slope_in = '0;
                        state_in = S_WALK;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  OP_READ: begin
                     row_in   = start_y;
                     state_in = S_RD_ISS;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_DIV: begin
            rem_in     = q_bit ? alu_sum[COORD_W-1:0] : trial[COORD_W-1:0];
            quo_in     = quo_next;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
               slope_in = neg_ff ? (XW'(0) - XW'(quo_next)) : XW'(quo_next);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // read this row now, write it back next cycle
            wr_pend_in = 1'b1;
            wr_row_in  = row_ff;
            wr_px_in   = x_ff[FRAC_W+COORD_W-1:FRAC_W];
            x_in       = alu_sum;
            row_in     = row_ff + COORD_W'(1);
            if (row_ff == y_hi_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         S_RD_ISS: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_left_in  = EXT_W'(rd_left);
               rsp_right_in = EXT_W'(rd_right);
               rsp_empty_in = (rd_left >= rd_right);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff   <= div_cnt_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dy_ff        <= dy_in;
      neg_ff       <= neg_in;
      slope_ff     <= slope_in;
      x_ff         <= x_in;
      row_ff       <= row_in;
      y_hi_ff      <= y_hi_in;
      wr_row_ff    <= wr_row_in;
      wr_px_ff     <= wr_px_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_right_ff, rsp_left_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_empty_ff;

endmodule

FILE: design/sef_checker.sv
module sef_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [sef_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [sef_pkg::OP_W-1:0]       req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sef_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                     rsp_tuser
);

   import sef_pkg::*;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready && (req_tdata == req_tdata);

   // reset starts the clearing pass: busy and nothing to deliver
   a_reset_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_tready && !rsp_tvalid))
      else $error("not busy after reset");

   // every real operation makes req_tready low in the cycle after it is taken
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser != OP_NONE) |=> !req_tready)
      else $error("ready straight after a request");

   // a response is only raised as a read finishes
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised while idle");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind scanline_span_extent_fill_top sef_checker u_sef_checker (.*);
